// ----- hdl/bti_pkg.sv -----
// Shared types, codes and constants for the breakpoint table interpolator.
package bti_pkg;

    // Table size used when the top level is not given another.
    localparam int TABLE_DEPTH_DEF = 64;

    // Widths of the Q16.16 values, the point count register and the slot field.
    localparam int VAL_W = 32;
    localparam int PC_W  = 7;
    localparam int IDX_W = 6;

    // Action codes of a request.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_D2T   = 2'd1;
    localparam logic [1:0] ACT_T2D   = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_RANGE   = 2'd1;
    localparam logic [1:0] STATUS_WRITTEN = 2'd2;

    // One request as it arrives.
    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] entry_time;
        logic [VAL_W-1:0] entry_depth;
        logic [VAL_W-1:0] query_value;
    } request_t;

    // One result as it leaves.
    typedef struct packed {
        logic [VAL_W-1:0] result_value;
        logic [1:0]       status;
    } result_t;

    // Range flags from the comparator row.
    typedef struct packed {
        logic lt_first;
        logic eq_first;
        logic lt_last;
        logic eq_last;
    } cmp_flags_t;

    // Data that rides alongside the divider.
    typedef struct packed {
        logic [VAL_W-1:0] base;
        logic             neg;
        logic             use_q;
        logic [1:0]       status;
    } div_side_t;

endpackage

// ----- hdl/bti_ram.sv -----
// Generic RAM with one write port and two registered read ports, read-first.
module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Storage and registered reads; a read in the same cycle as a write sees old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- hdl/bti_cells.sv -----
// Row of breakpoint cells, each comparing its stored value against the probe.
module bti_cells #(
    parameter int TABLE_DEPTH = bti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           write_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] write_addr,
    input  logic [bti_pkg::VAL_W-1:0]      write_time,
    input  logic [bti_pkg::VAL_W-1:0]      write_depth,
    input  logic                           time_axis,
    input  logic [bti_pkg::VAL_W-1:0]      probe,
    input  logic [$clog2(TABLE_DEPTH)-1:0] last_addr,
    output logic [TABLE_DEPTH-1:0]         above_vec,
    output bti_pkg::cmp_flags_t            flags
);

    import bti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [VAL_W-1:0]       time_cells_reg  [TABLE_DEPTH];
    logic [VAL_W-1:0]       depth_cells_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] above_all;
    logic [TABLE_DEPTH-1:0] equal_all;
    logic [TABLE_DEPTH-1:0] last_oh;

    // Cell storage.
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            time_cells_reg[write_addr]  <= write_time;
            depth_cells_reg[write_addr] <= write_depth;
        end
    end

    // Each cell compares its source-axis value with the probe.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic [VAL_W-1:0] src;
        assign src          = time_axis ? time_cells_reg[g] : depth_cells_reg[g];
        assign above_all[g] = src > probe;
        assign equal_all[g] = src == probe;
        assign last_oh[g]   = AW'(g) == last_addr;
        if (g == 0)
        begin : g_first
            assign above_vec[g] = 1'b0;
        end
        else
        begin : g_rest
            assign above_vec[g] = above_all[g] && (AW'(g) <= last_addr);
        end
    end

    // Range flags against the first and last breakpoint in use.
    assign flags.lt_first = above_all[0];
    assign flags.eq_first = equal_all[0];
    assign flags.lt_last  = |(above_all & last_oh);
    assign flags.eq_last  = |(equal_all & last_oh);

endmodule

// ----- hdl/bti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for a 64 by 32 bit quotient.
module bti_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2*bti_pkg::VAL_W-1:0] in_prod,
    input  logic [bti_pkg::VAL_W-1:0]   in_den,
    input  bti_pkg::div_side_t          in_side,
    output logic                        out_valid,
    output logic [bti_pkg::VAL_W-1:0]   out_quot,
    output bti_pkg::div_side_t          out_side
);

    import bti_pkg::*;

    localparam int STEPS = VAL_W;

    logic             valid_reg [STEPS];
    logic [VAL_W-1:0] rem_reg   [STEPS];
    logic [VAL_W-1:0] low_reg   [STEPS];
    logic [VAL_W-1:0] quot_reg  [STEPS];
    logic [VAL_W-1:0] den_reg   [STEPS];
    div_side_t        side_reg  [STEPS];

    for (genvar g = 0; g < STEPS; g++)
    begin : g_step
        logic             valid_prev;
        logic [VAL_W-1:0] rem_prev;
        logic [VAL_W-1:0] low_prev;
        logic [VAL_W-1:0] quot_prev;
        logic [VAL_W-1:0] den_prev;
        div_side_t        side_prev;
        logic [VAL_W+1:0] trial;
        logic             take;

        // Stage input: the dividend enters at the first stage.
        if (g == 0)
        begin : g_head
            assign valid_prev = in_valid;
            assign rem_prev   = in_prod[2*VAL_W-1:VAL_W];
            assign low_prev   = in_prod[VAL_W-1:0];
            assign quot_prev  = '0;
            assign den_prev   = in_den;
            assign side_prev  = in_side;
        end
        else
        begin : g_body
            assign valid_prev = valid_reg[g-1];
            assign rem_prev   = rem_reg[g-1];
            assign low_prev   = low_reg[g-1];
            assign quot_prev  = quot_reg[g-1];
            assign den_prev   = den_reg[g-1];
            assign side_prev  = side_reg[g-1];
        end

        // Shift in one dividend bit and subtract when the divisor fits; the shifted
        // remainder can reach 33 bits, so the trial keeps a separate sign bit.
        assign trial = {1'b0, rem_prev, low_prev[VAL_W-1]} - {2'b00, den_prev};
        assign take  = !trial[VAL_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= take ? trial[VAL_W-1:0]
                                    : {rem_prev[VAL_W-2:0], low_prev[VAL_W-1]};
                low_reg[g]  <= {low_prev[VAL_W-2:0], 1'b0};
                quot_reg[g] <= {quot_prev[VAL_W-2:0], take};
                den_reg[g]  <= den_prev;
                side_reg[g] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_quot  = quot_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hdl/bidirectional_table_interpolator_unit.sv -----
// Top level of the breakpoint table interpolator: request pipeline, table and result register.
// Converts depth to time or time to depth through a table of up to TABLE_DEPTH breakpoint
// pairs, both axes unsigned Q16.16. Write requests store one pair; queries find their segment
// in a row of parallel comparators, read the two bracketing pairs from dual-read RAMs,
// multiply and divide in a pipeline, and return a truncated interpolation or the out-of-range
// status. A new request is taken every clock cycle unless a finished result is held by a stall.
// Each request passes 39 register stages (six front stages, the 32 stages of the bit-per-stage
// divider and the result register); the first captures it at the accepting edge. A held
// result freezes the whole pipeline. Writes reach the comparator row and the RAMs in request
// order, so a query sees every write accepted before it. The user must change point_count only
// while no request is in flight; the block itself does not enforce this.
module bidirectional_table_interpolator_unit #(
    parameter int TABLE_DEPTH = bti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     config_write,
    input  logic [bti_pkg::PC_W-1:0] config_data,
    input  logic                     request_valid,
    output logic                     request_stall,
    input  bti_pkg::request_t        request,
    output logic                     result_valid,
    input  logic                     result_stall,
    output bti_pkg::result_t         result
);

    import bti_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   en;
    logic [PC_W-1:0]        point_count_reg;
    logic [31:0]            count_eff;
    logic [AW-1:0]          last_addr;

    logic                   s1_valid_reg;
    request_t               s1_req_reg;
    logic                   s1_idx_ok;
    logic                   cells_we;
    logic [TABLE_DEPTH-1:0] cells_above;
    cmp_flags_t             cells_flags;

    logic                   s2_valid_reg;
    request_t               s2_req_reg;
    logic [TABLE_DEPTH-1:0] s2_above_reg;
    cmp_flags_t             s2_flags_reg;
    logic [TABLE_DEPTH-1:0] s2_hit;
    logic                   s2_is_query;
    logic                   s2_out_range;
    logic [1:0]             s2_status;
    logic                   s2_interp;

    logic                   s3_valid_reg;
    request_t               s3_req_reg;
    logic [TABLE_DEPTH-1:0] s3_hit_reg;
    logic [1:0]             s3_status_reg;
    logic                   s3_snap_first_reg;
    logic                   s3_snap_last_reg;
    logic [AW-1:0]          s3_hi_addr;
    logic [AW-1:0]          rd_lo;
    logic [AW-1:0]          rd_hi;
    logic                   ram_we;

    logic                   s4_valid_reg;
    logic [VAL_W-1:0]       s4_x_reg;
    logic                   s4_time_axis_reg;
    logic [1:0]             s4_status_reg;
    logic                   s4_snap_reg;
    logic [VAL_W-1:0]       time_lo;
    logic [VAL_W-1:0]       time_hi;
    logic [VAL_W-1:0]       depth_lo;
    logic [VAL_W-1:0]       depth_hi;
    logic [VAL_W-1:0]       x_lo;
    logic [VAL_W-1:0]       x_hi;
    logic [VAL_W-1:0]       f_lo;
    logic [VAL_W-1:0]       f_hi;
    logic [VAL_W-1:0]       s4_num;
    logic [VAL_W-1:0]       s4_den;
    logic [VAL_W-1:0]       s4_diff;
    logic                   s4_neg;

    logic                   s5_valid_reg;
    logic [VAL_W-1:0]       s5_num_reg;
    logic [VAL_W-1:0]       s5_diff_reg;
    logic [VAL_W-1:0]       s5_den_reg;
    div_side_t              s5_side_reg;
    logic [2*VAL_W-1:0]     s5_prod;

    logic                   s6_valid_reg;
    logic [2*VAL_W-1:0]     s6_prod_reg;
    logic [VAL_W-1:0]       s6_den_reg;
    div_side_t              s6_side_reg;

    logic                   div_valid;
    logic [VAL_W-1:0]       div_quot;
    div_side_t              div_side;

    logic                   result_valid_reg;
    result_t                result_reg;
    result_t                result_next;

    // The whole pipeline advances unless a finished result is held up.
    assign en            = !(result_valid_reg && result_stall);
    assign request_stall = !en;

    // Point count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= PC_W'(2);
        end
        else if (config_write)
        begin
            point_count_reg <= config_data;
        end
    end

    // Effective count, clamped to the table, and the index of the last breakpoint in use.
    always_comb
    begin
        count_eff = 32'(point_count_reg);
        if (count_eff < 32'd2)
        begin
            count_eff = 32'd2;
        end
        if (count_eff > 32'(TABLE_DEPTH))
        begin
            count_eff = 32'(TABLE_DEPTH);
        end
        last_addr = AW'(count_eff - 32'd1);
    end

    // Stage 1: request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= request_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg <= request;
        end
    end

    // Writes commit to the comparator row as they leave stage 1.
    assign s1_idx_ok = 32'(s1_req_reg.entry_index) < 32'(TABLE_DEPTH);
    assign cells_we  = en && s1_valid_reg && (s1_req_reg.action == ACT_WRITE) && s1_idx_ok;

    bti_cells #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_cells (
        .clk         (clk),
        .write_en    (cells_we),
        .write_addr  (AW'(s1_req_reg.entry_index)),
        .write_time  (s1_req_reg.entry_time),
        .write_depth (s1_req_reg.entry_depth),
        .time_axis   (s1_req_reg.action == ACT_T2D),
        .probe       (s1_req_reg.query_value),
        .last_addr   (last_addr),
        .above_vec   (cells_above),
        .flags       (cells_flags)
    );

    // Stage 2: comparator results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_req_reg   <= s1_req_reg;
            s2_above_reg <= cells_above;
            s2_flags_reg <= cells_flags;
        end
    end

    // First breakpoint above the query, isolated as a one-hot vector, and the status.
    assign s2_hit = s2_above_reg & ((~s2_above_reg) + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
    assign s2_is_query  = (s2_req_reg.action == ACT_D2T) || (s2_req_reg.action == ACT_T2D);
    assign s2_out_range = s2_flags_reg.lt_first
                          || (!s2_flags_reg.lt_last && !s2_flags_reg.eq_last);

    always_comb
    begin
        priority if (s2_req_reg.action == ACT_WRITE)
        begin
            s2_status = STATUS_WRITTEN;
        end
        else if (!s2_is_query || s2_out_range)
        begin
            s2_status = STATUS_RANGE;
        end
        else
        begin
            s2_status = STATUS_OK;
        end
    end

    assign s2_interp = s2_valid_reg && (s2_status == STATUS_OK)
                       && !s2_flags_reg.eq_first && s2_flags_reg.lt_last;

    // Stage 3: segment selection.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_req_reg        <= s2_req_reg;
            s3_hit_reg        <= s2_hit;
            s3_status_reg     <= s2_status;
            s3_snap_first_reg <= s2_flags_reg.eq_first;
            s3_snap_last_reg  <= !s2_flags_reg.lt_last;
        end
    end

    // Encode the one-hot hit into the upper index of the segment.
    always_comb
    begin
        s3_hi_addr = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (s3_hit_reg[i])
            begin
                s3_hi_addr = s3_hi_addr | AW'(i);
            end
        end
    end

    // Read addresses; a query on the first or last breakpoint reads that pair alone.
    always_comb
    begin
        priority if (s3_snap_first_reg)
        begin
            rd_lo = '0;
            rd_hi = '0;
        end
        else if (s3_snap_last_reg)
        begin
            rd_lo = last_addr;
            rd_hi = last_addr;
        end
        else
        begin
            rd_lo = s3_hi_addr - AW'(1);
            rd_hi = s3_hi_addr;
        end
    end

    // Writes commit to the RAMs as they leave stage 3, in step with the reads.
    assign ram_we = en && s3_valid_reg && (s3_req_reg.action == ACT_WRITE)
                    && (32'(s3_req_reg.entry_index) < 32'(TABLE_DEPTH));

    bti_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_time_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (AW'(s3_req_reg.entry_index)),
        .wdata   (s3_req_reg.entry_time),
        .re      (en),
        .raddr_a (rd_lo),
        .raddr_b (rd_hi),
        .rdata_a (time_lo),
        .rdata_b (time_hi)
    );

    bti_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_depth_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (AW'(s3_req_reg.entry_index)),
        .wdata   (s3_req_reg.entry_depth),
        .re      (en),
        .raddr_a (rd_lo),
        .raddr_b (rd_hi),
        .rdata_a (depth_lo),
        .rdata_b (depth_hi)
    );

    // Stage 4: bracketing pairs from the RAMs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_x_reg         <= s3_req_reg.query_value;
            s4_time_axis_reg <= s3_req_reg.action == ACT_T2D;
            s4_status_reg    <= s3_status_reg;
            s4_snap_reg      <= s3_snap_first_reg || s3_snap_last_reg;
        end
    end

    // Pick source and target axes, then form numerator, span and signed rise.
    assign x_lo    = s4_time_axis_reg ? time_lo  : depth_lo;
    assign x_hi    = s4_time_axis_reg ? time_hi  : depth_hi;
    assign f_lo    = s4_time_axis_reg ? depth_lo : time_lo;
    assign f_hi    = s4_time_axis_reg ? depth_hi : time_hi;
    assign s4_num  = s4_snap_reg ? '0 : s4_x_reg - x_lo;
    assign s4_den  = x_hi - x_lo;
    assign s4_neg  = f_hi < f_lo;
    assign s4_diff = s4_neg ? f_lo - f_hi : f_hi - f_lo;

    // Stage 5: multiplier operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_num_reg         <= s4_num;
            s5_diff_reg        <= s4_diff;
            s5_den_reg         <= s4_den;
            s5_side_reg.base   <= f_lo;
            s5_side_reg.neg    <= s4_neg;
            s5_side_reg.use_q  <= !s4_snap_reg;
            s5_side_reg.status <= s4_status_reg;
        end
    end

    assign s5_prod = (2*VAL_W)'(s5_num_reg) * (2*VAL_W)'(s5_diff_reg);

    // Stage 6: product register feeding the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_prod_reg <= s5_prod;
            s6_den_reg  <= s5_den_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    bti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s6_valid_reg),
        .in_prod   (s6_prod_reg),
        .in_den    (s6_den_reg),
        .in_side   (s6_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Final value: zero unless status is OK, the end value on a breakpoint, else the interpolation.
    always_comb
    begin
        result_next.status = div_side.status;
        priority if (div_side.status != STATUS_OK)
        begin
            result_next.result_value = '0;
        end
        else if (!div_side.use_q)
        begin
            result_next.result_value = div_side.base;
        end
        else if (div_side.neg)
        begin
            result_next.result_value = div_side.base - div_quot;
        end
        else
        begin
            result_next.result_value = div_side.base + div_quot;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An interpolating query always finds a breakpoint above it, so its hit vector is one-hot.
    a_single_hit : assert property (@(posedge clk) disable iff (!rst_n)
        (en && s2_interp) |=> $onehot(s3_hit_reg))
        else $error("interpolating query without a single bracketing breakpoint");

    // A query that lands on a breakpoint must reach the multiplier with a zero numerator.
    a_snap_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (s5_valid_reg && !s5_side_reg.use_q) |-> (s5_num_reg == '0))
        else $error("breakpoint hit carries a non-zero numerator");

    // The request side is held only while a finished result waits.
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |-> (result_valid && result_stall))
        else $error("request stalled without a waiting result");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the breakpoint table interpolator: stimulus, prediction and checking.
`timescale 1ns / 100ps

module tb_top;
    import bti_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int DRAIN_CYC = 60;
    localparam int DOG_LIMIT = 20000;

    // Scoreboard: holds the table copy and the queue of predicted results.
    class interp_scoreboard;
        logic [31:0] time_tab[DEPTH];
        logic [31:0] depth_tab[DEPTH];
        logic [6:0]  count_reg;
        result_t     pending[$];
        int          mismatches;

        function void reset_state();
            count_reg  = 7'd2;
            mismatches = 0;
            pending.delete();
        endfunction

        // Interpolates x along source axis xp onto fp; returns 0 when out of range.
        function bit interpolate(bit d2t, logic [31:0] x, output logic [31:0] val);
            logic [31:0] xp[DEPTH];
            logic [31:0] fp[DEPTH];
            int n, hi, lo;
            logic [31:0] den, num, flo, fhi;
            logic [63:0] prod;
            n = count_reg < 2 ? 2 : (count_reg > DEPTH ? DEPTH : count_reg);
            if (d2t)
            begin
                xp = depth_tab;
                fp = time_tab;
            end
            else
            begin
                xp = time_tab;
                fp = depth_tab;
            end
            val = '0;
            if (x < xp[0] || x > xp[n-1]) return 0;
            if (x == xp[0]) begin val = fp[0]; return 1; end
            if (x >= xp[n-1]) begin val = fp[n-1]; return 1; end
            hi = n - 1;
            for (int i = n - 1; i >= 1; i--)
                if (xp[i] > x) hi = i;
            lo = hi - 1;
            den = xp[hi] - xp[lo];
            num = x - xp[lo];
            flo = fp[lo];
            fhi = fp[hi];
            if (fhi >= flo)
            begin
                prod = {32'd0, num} * {32'd0, fhi - flo};
                val = flo + 32'(prod / den);
            end
            else
            begin
                prod = {32'd0, num} * {32'd0, flo - fhi};
                val = flo - 32'(prod / den);
            end
            return 1;
        endfunction

        // Notes one accepted request and queues the result it should give.
        function void note_request(request_t rq);
            result_t r;
            logic [31:0] v;
            r = '0;
            if (rq.action == ACT_WRITE)
            begin
                time_tab[rq.entry_index]  = rq.entry_time;
                depth_tab[rq.entry_index] = rq.entry_depth;
                r.status = STATUS_WRITTEN;
            end
            else if ((rq.action == ACT_D2T || rq.action == ACT_T2D) &&
                     interpolate(rq.action == ACT_D2T, rq.query_value, v))
            begin
                r.result_value = v;
                r.status = STATUS_OK;
            end
            else
                r.status = STATUS_RANGE;
            pending.insert(pending.size(), r);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(result_t got);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h status=%0d",
                             got.result_value, got.status);
                return;
            end
            exp_r = pending.pop_front();
            if (got.result_value !== exp_r.result_value || got.status !== exp_r.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                             exp_r.result_value, exp_r.status, got.result_value, got.status);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       config_write;
    logic [6:0] config_data;
    logic       request_valid;
    logic       request_stall;
    request_t   request;
    logic       result_valid;
    logic       result_stall;
    result_t    result;

    interp_scoreboard sb;
    bit  quiet_phase;
    int  dog;

    // Times and depths of the breakpoints as last laid down, for query selection.
    logic [31:0] bp_time[DEPTH];
    logic [31:0] bp_depth[DEPTH];
    int          written_upto;

    bidirectional_table_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .config_write(config_write), .config_data(config_data),
        .request_valid(request_valid), .request_stall(request_stall), .request(request),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor and result-side stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_valid && !request_stall) sb.note_request(request);
            if (result_valid && !result_stall) sb.check_result(result);
            if ((request_valid && !request_stall) || (result_valid && !result_stall))
                dog <= 0;
            else
                dog <= dog + 1;
            result_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 6);
        end
    end

    // Watchdog on progress.
    always @(posedge clk)
    begin
        if (dog >= DOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one request, with a random idle gap before it.
    task automatic send_request(request_t rq);
        while (!quiet_phase && $urandom_range(99) < 6)
        begin
            request_valid <= 1'b0;
            @(posedge clk);
        end
        request_valid <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (request_stall) @(posedge clk);
    endtask

    task automatic send_write(int idx, logic [31:0] t, logic [31:0] d);
        request_t rq;
        rq = '0;
        rq.action = ACT_WRITE;
        rq.entry_index = idx[5:0];
        rq.entry_time = t;
        rq.entry_depth = d;
        rq.query_value = $urandom;
        send_request(rq);
    endtask

    task automatic send_query(logic [1:0] act, logic [31:0] q);
        request_t rq;
        rq.action = act;
        rq.entry_index = 6'($urandom);
        rq.entry_time = $urandom;
        rq.entry_depth = $urandom;
        rq.query_value = q;
        send_request(rq);
    endtask

    // Waits until every prediction has been met, then lets the pipeline drain.
    task automatic wait_idle();
        request_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_count(logic [6:0] n);
        config_write <= 1'b1;
        config_data <= n;
        @(posedge clk);
        config_write <= 1'b0;
        sb.count_reg = n;
    endtask

    // Fills slots 0..n-1 with increasing axes; steps are random, sometimes huge.
    task automatic load_table(int n, bit wide);
        logic [31:0] t, d;
        int span;
        span = wide ? (32'hFFFF_FFF0 / n) : 32'h0004_0000;
        t = wide ? 32'd0 : $urandom_range(32'h0010_0000);
        d = wide ? 32'd0 : $urandom_range(32'h0010_0000);
        for (int i = 0; i < n; i++)
        begin
            bp_time[i] = t;
            bp_depth[i] = d;
            send_write(i, t, d);
            t = t + 1 + $urandom_range(span - 1);
            d = d + 1 + $urandom_range(span - 1);
        end
        if (n > written_upto) written_upto = n;
    endtask

    // Picks a query value: on a breakpoint, inside a segment or out of range.
    function automatic logic [31:0] pick_query(bit d2t, int n);
        logic [31:0] lo_v, hi_v;
        int k;
        lo_v = d2t ? bp_depth[0] : bp_time[0];
        hi_v = d2t ? bp_depth[n-1] : bp_time[n-1];
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0: return lo_v;
            1: return hi_v;
            2: return d2t ? bp_depth[k] : bp_time[k];
            3: return lo_v == 0 ? $urandom : $urandom_range(lo_v - 1);
            4: return hi_v == 32'hFFFF_FFFF ? hi_v : hi_v + 1 + $urandom_range(~hi_v - 1);
            5: return $urandom;
            default: return lo_v + $urandom_range(hi_v - lo_v);
        endcase
    endfunction

    initial
    begin
        int n;
        logic [1:0] act;
        request_t rq;
        sb = new();
        sb.reset_state();
        rst_n = 1'b0;
        config_write = 1'b0;
        config_data = '0;
        request_valid = 1'b0;
        request = '0;
        result_stall = 1'b0;
        quiet_phase = 1'b0;
        dog = 0;
        written_upto = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset count of two, full-scale table, field extremes.
        send_write(0, 32'd0, 32'd0);
        send_write(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        bp_time[0] = 0; bp_depth[0] = 0;
        bp_time[1] = '1; bp_depth[1] = '1;
        written_upto = 2;
        send_query(ACT_D2T, 32'd0);
        send_query(ACT_T2D, 32'hFFFF_FFFF);
        send_query(ACT_D2T, 32'h8000_0001);
        send_query(ACT_T2D, 32'h7FFF_FFFF);
        // Decreasing depth against increasing time, out-of-range and unused action.
        send_write(1, 32'hFFFF_FFFF, 32'd0);
        send_write(0, 32'd5, 32'hFFFF_FFFF);
        bp_time[0] = 5; bp_depth[0] = '1; bp_time[1] = '1; bp_depth[1] = 0;
        send_query(ACT_T2D, 32'd4);
        send_query(ACT_T2D, 32'h1234_5678);
        send_query(ACT_D2T, 32'hABCD_0000);
        send_query(2'd3, 32'h0000_0010);
        // Write beyond the table is not possible with six index bits; slot 63 is the top.
        send_write(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // Count above the table saturates; fill every slot.
        write_count(7'd127);
        load_table(DEPTH, 1'b1);
        for (int i = 0; i < 20; i++)
            send_query($urandom_range(1) ? ACT_D2T : ACT_T2D,
                       pick_query($urandom_range(1), DEPTH));
        wait_idle();

        // Count zero saturates to two.
        write_count(7'd0);
        send_query(ACT_T2D, pick_query(1'b0, 2));
        send_query(ACT_D2T, pick_query(1'b1, 2));
        wait_idle();

        // Random phases with several counts, mostly small.
        for (int ph = 0; ph < 10; ph++)
        begin
            quiet_phase = (ph == 4);
            case (ph)
                0: n = 2;
                1: n = 64;
                2: n = 63;
                default: n = 2 + $urandom_range(14);
            endcase
            write_count(n[6:0]);
            load_table(n, ph % 3 == 1);
            for (int i = 0; i < 25; i++)
            begin
                if ($urandom_range(99) < 4)
                begin
                    // Noise: a rewrite of a used slot with random pairs or an unused action.
                    if ($urandom_range(1))
                    begin
                        rq = '0;
                        rq.action = 2'd3;
                        rq.query_value = $urandom;
                        rq.entry_index = 6'($urandom);
                        send_request(rq);
                    end
                    else
                    begin
                        int k;
                        k = $urandom_range(n - 1);
                        bp_time[k] = $urandom;
                        bp_depth[k] = $urandom;
                        send_write(k, bp_time[k], bp_depth[k]);
                    end
                end
                else
                begin
                    act = $urandom_range(1) ? ACT_D2T : ACT_T2D;
                    send_query(act, pick_query(act == ACT_D2T, n));
                end
            end
            wait_idle();
        end
        quiet_phase = 1'b0;

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
